@@ rtl/b58dec_pkg.sv @@
// b58dec_pkg: shared constants, types and the alphabet lookup of the base58 decoder
// used by b58dec_ctrl, b58dec_datapath and the top level; depends on nothing
package b58dec_pkg;

	// size of the big number and derived widths
	localparam int NUM_BYTES = 64;
	localparam int ADDR_W    = $clog2(NUM_BYTES);
	localparam int LEN_W     = $clog2(NUM_BYTES + 1);

	// fixed result limits
	localparam int MAX_OUT   = 64;
	localparam int ZERO_SAT  = 65;
	localparam int RADIX     = 58;

	// character codes
	localparam logic [7:0] CH_ONE  = 8'h31;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_UA   = 8'h41;
	localparam logic [7:0] CH_UH   = 8'h48;
	localparam logic [7:0] CH_UJ   = 8'h4A;
	localparam logic [7:0] CH_UN   = 8'h4E;
	localparam logic [7:0] CH_UP   = 8'h50;
	localparam logic [7:0] CH_UZ   = 8'h5A;
	localparam logic [7:0] CH_LA   = 8'h61;
	localparam logic [7:0] CH_LK   = 8'h6B;
	localparam logic [7:0] CH_LM   = 8'h6D;
	localparam logic [7:0] CH_LZ   = 8'h7A;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_CHAR = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_CAPACITY = 2'd3
	} status_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] val;
	} digit_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic mac_start;
		logic mac_rd;
		logic end_calc;
		logic emit;
		logic clear;
	} b58dec_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic mac_req;
		logic mac_last;
		logic eos_q;
		logic emit_done;
	} b58dec_sts_t;

	// alphabet lookup: characters 0, I, O and l are not digits
	function automatic digit_t digit_of(input logic [7:0] c);
		digit_t d;
		d.ok  = 1'b1;
		d.val = '0;
		if (c >= CH_ONE && c <= CH_NINE) begin
			d.val = 6'(c - CH_ONE);
		end else if (c >= CH_UA && c <= CH_UH) begin
			d.val = 6'(c - CH_UA) + 6'd9;
		end else if (c >= CH_UJ && c <= CH_UN) begin
			d.val = 6'(c - CH_UJ) + 6'd17;
		end else if (c >= CH_UP && c <= CH_UZ) begin
			d.val = 6'(c - CH_UP) + 6'd22;
		end else if (c >= CH_LA && c <= CH_LK) begin
			d.val = 6'(c - CH_LA) + 6'd33;
		end else if (c >= CH_LM && c <= CH_LZ) begin
			d.val = 6'(c - CH_LM) + 6'd44;
		end else begin
			d.ok = 1'b0;
		end
		return d;
	endfunction

endpackage

@@ rtl/b58dec_ram.sv @@
// b58dec_ram: generic simple dual-port RAM, one write and one registered read port
// no dependencies
module b58dec_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/b58dec_datapath.sv @@
// b58dec_datapath: big number store, multiply-accumulate sweep, length and error
// tracking, and the result pipeline; depends on b58dec_pkg and b58dec_ram
module b58dec_datapath
	import b58dec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  b58dec_cmd_t cmd,
	output b58dec_sts_t sts,
	input  logic        cfg_wr_en,
	input  logic [6:0]  cfg_wr_data,
	input  logic [7:0]  char_code,
	input  logic        has_char,
	input  logic        end_of_string,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  data_byte,
	output logic        has_byte,
	output logic [1:0]  status,
	output logic [6:0]  total_length,
	output logic        last_byte
);

	// string state
	logic [6:0]           cap_q;
	logic [6:0]           lz_q;
	logic                 past_q;
	status_t              err_q;
	logic                 eos_q;
	logic [LEN_W-1:0]     len_q;
	logic [NUM_BYTES-1:0] valid_q;

	// sweep state
	logic [ADDR_W-1:0]    idx_q;
	logic [6:0]           carry_q;
	logic                 mac_s1;
	logic [ADDR_W-1:0]    wr_idx_s1;
	logic                 rd_vld_s1;

	// result state
	logic [6:0]           k_q;
	logic [6:0]           n_q;
	logic [6:0]           tl_q;
	logic                 single_q;
	logic [ADDR_W-1:0]    rd_ptr_q;
	logic                 emit_s1;
	logic                 zero_s1;
	logic                 last_s1;
	logic                 out_vld_q;
	logic [7:0]           out_byte_q;
	logic                 out_has_q;
	logic [1:0]           out_st_q;
	logic [6:0]           out_tl_q;
	logic                 out_last_q;

	// ram ports
	logic                 ram_we;
	logic                 ram_re;
	logic [ADDR_W-1:0]    ram_raddr;
	logic [7:0]           ram_rdata;
	logic [7:0]           ram_wdata;

	// combinational helpers
	digit_t               dig;
	logic                 lead_one;
	logic [7:0]           rd_byte;
	logic [14:0]          mac_sum;
	logic [7:0]           total;
	logic [6:0]           cap_eff;
	status_t              end_err;
	logic                 end_single;
	logic                 out_free;
	logic                 s1_adv;
	logic                 issue;
	logic                 issue_zero;

	// input word classification
	assign dig      = digit_of(char_code);
	assign lead_one = !past_q && (char_code == CH_ONE);

	assign sts.mac_req   = has_char && !lead_one && (err_q == ST_OK) && dig.ok;
	assign sts.mac_last  = (idx_q == '0);
	assign sts.eos_q     = eos_q;
	assign sts.emit_done = (k_q == n_q) && !emit_s1;

	// read byte, unwritten entries read as zero
	assign rd_byte = rd_vld_s1 ? ram_rdata : 8'd0;

	// byte times radix plus carry
	assign mac_sum   = 15'(rd_byte) * 15'(RADIX) + 15'(carry_q);
	assign ram_we    = mac_s1;
	assign ram_wdata = mac_sum[7:0];

	// end of string: length and capacity check
	assign total      = 8'(lz_q) + 8'(len_q);
	assign cap_eff    = (cap_q > 7'(MAX_OUT)) ? 7'(MAX_OUT) : cap_q;
	assign end_err    = (err_q != ST_OK) ? err_q :
	                    (total > {1'b0, cap_eff}) ? ST_CAPACITY : ST_OK;
	assign end_single = (end_err != ST_OK) || (total == 8'd0);

	// result pipeline handshake
	assign out_free   = !out_vld_q || !out_stall;
	assign s1_adv     = emit_s1 && out_free;
	assign issue      = cmd.emit && (k_q != n_q) && (!emit_s1 || out_free);
	assign issue_zero = single_q || (k_q < lz_q);

	assign ram_re    = cmd.mac_rd || (issue && !issue_zero);
	assign ram_raddr = cmd.mac_rd ? idx_q : rd_ptr_q;

	b58dec_ram #(
		.WIDTH(8),
		.DEPTH(NUM_BYTES)
	) u_num_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_idx_s1),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 7'(MAX_OUT);
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// per-string state: leading ones, sticky error, value length, entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lz_q    <= '0;
			past_q  <= 1'b0;
			err_q   <= ST_OK;
			eos_q   <= 1'b0;
			len_q   <= '0;
			valid_q <= '0;
		end else begin
			if (cmd.accept) begin
				eos_q <= end_of_string;
				if (has_char) begin
					if (lead_one) begin
						if (lz_q < 7'(ZERO_SAT)) begin
							lz_q <= lz_q + 7'd1;
						end
					end else begin
						past_q <= 1'b1;
						if (err_q == ST_OK && !dig.ok) begin
							err_q <= ST_BAD_CHAR;
						end
					end
				end
			end
			if (cmd.mac_start) begin
				len_q <= '0;
			end
			if (mac_s1) begin
				valid_q[wr_idx_s1] <= 1'b1;
				if (mac_sum[7:0] != 8'd0) begin
					len_q <= LEN_W'(NUM_BYTES) - LEN_W'(wr_idx_s1);
				end
				if (wr_idx_s1 == '0 && mac_sum[14:8] != 7'd0) begin
					err_q <= ST_OVERFLOW;
				end
			end
			if (cmd.end_calc) begin
				err_q <= end_err;
			end
			if (cmd.clear) begin
				lz_q    <= '0;
				past_q  <= 1'b0;
				err_q   <= ST_OK;
				len_q   <= '0;
				valid_q <= '0;
			end
		end
	end

	// sweep control: read index and write stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			mac_s1 <= 1'b0;
		end else begin
			mac_s1 <= cmd.mac_rd;
			if (cmd.mac_start) begin
				idx_q <= ADDR_W'(NUM_BYTES - 1);
			end else if (cmd.mac_rd) begin
				idx_q <= idx_q - ADDR_W'(1);
			end
		end
	end

	// sweep payload: carry chain, write address, entry valid sample
	always_ff @(posedge clk) begin
		if (cmd.mac_start) begin
			carry_q <= 7'(dig.val);
		end else if (mac_s1) begin
			carry_q <= mac_sum[14:8];
		end
		if (cmd.mac_rd) begin
			wr_idx_s1 <= idx_q;
		end
		if (ram_re) begin
			rd_vld_s1 <= valid_q[ram_raddr];
		end
	end

	// result sequencing counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			n_q     <= '0;
			emit_s1 <= 1'b0;
		end else begin
			if (cmd.end_calc) begin
				k_q <= '0;
				n_q <= end_single ? 7'd1 : total[6:0];
			end else if (issue) begin
				k_q <= k_q + 7'd1;
			end
			if (issue) begin
				emit_s1 <= 1'b1;
			end else if (s1_adv) begin
				emit_s1 <= 1'b0;
			end
		end
	end

	// result sequencing payload
	always_ff @(posedge clk) begin
		if (cmd.end_calc) begin
			single_q <= end_single;
			tl_q     <= end_single ? 7'd0 : total[6:0];
			rd_ptr_q <= ADDR_W'(LEN_W'(NUM_BYTES) - len_q);
		end else if (issue && !issue_zero) begin
			rd_ptr_q <= rd_ptr_q + ADDR_W'(1);
		end
		if (issue) begin
			zero_s1 <= issue_zero;
			last_s1 <= (k_q + 7'd1) == n_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_adv) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_byte_q <= zero_s1 ? 8'd0 : rd_byte;
			out_has_q  <= !single_q;
			out_st_q   <= err_q;
			out_tl_q   <= tl_q;
			out_last_q <= last_s1;
		end
	end

	assign out_valid    = out_vld_q;
	assign data_byte    = out_byte_q;
	assign has_byte     = out_has_q;
	assign status       = out_st_q;
	assign total_length = out_tl_q;
	assign last_byte    = out_last_q;

endmodule

@@ rtl/b58dec_ctrl.sv @@
// b58dec_ctrl: controller state machine of the base58 decoder
// depends on b58dec_pkg; drives commands to b58dec_datapath
module b58dec_ctrl
	import b58dec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        end_of_string,
	output logic        in_stall,
	input  b58dec_sts_t sts,
	output b58dec_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MAC  = 5'b00010,
		S_TAIL = 5'b00100,
		S_END  = 5'b01000,
		S_EMIT = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (sts.mac_req) begin
						cmd.mac_start = 1'b1;
						state_d       = S_MAC;
					end else if (end_of_string) begin
						state_d = S_END;
					end
				end
			end
			S_MAC: begin
				cmd.mac_rd = 1'b1;
				if (sts.mac_last) begin
					state_d = S_TAIL;
				end
			end
			S_TAIL: begin
				state_d = sts.eos_q ? S_END : S_IDLE;
			end
			S_END: begin
				cmd.end_calc = 1'b1;
				state_d      = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				if (sts.emit_done) begin
					cmd.clear = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/base58_string_decoder_top.sv @@
// base58_string_decoder_top: top level of the base58 string decoder
// depends on b58dec_pkg, b58dec_ctrl and b58dec_datapath
//
// Decodes a base58 string given one character per input word, without checksum. Leading
// '1' characters count as zero bytes (saturating at 65); every other character is folded
// into a NUM_BYTES-byte big number held in a small RAM. A character that enters the
// number is accepted and then folded in by a read-modify-write of one byte per cycle over
// the whole number, set by the single RAM write port. Leading ones, characters after an
// error, and words without a character are only accepted. The word that ends the string
// leads to a length and capacity check, then the results follow at one word per cycle
// while out_stall is low, the first passing through the read stage and the output
// register; the next string is accepted once the last result has entered the output
// register. Errors give a single result with has_byte low and a nonzero status; an empty
// string gives a single result with status ok and total_length zero.
module base58_string_decoder_top
	import b58dec_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [6:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       has_char,
	input  logic       end_of_string,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] data_byte,
	output logic       has_byte,
	output logic [1:0] status,
	output logic [6:0] total_length,
	output logic       last_byte
);

	b58dec_cmd_t cmd;
	b58dec_sts_t sts;

	// controller
	b58dec_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.end_of_string(end_of_string),
		.in_stall     (in_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	// datapath
	b58dec_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.char_code    (char_code),
		.has_char     (has_char),
		.end_of_string(end_of_string),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.data_byte    (data_byte),
		.has_byte     (has_byte),
		.status       (status),
		.total_length (total_length),
		.last_byte    (last_byte)
	);

endmodule
